// ----- rtl/core/tpc_pkg.sv -----
// tpc_pkg: shared types and fixed constants of the triangle point classifier.
// No dependencies.
`default_nettype none
package tpc_pkg;

  localparam int OUT_IDX_BITS = 16;

  typedef struct packed {
    logic                    inside_res;
    logic                    step_found;
    logic [OUT_IDX_BITS-1:0] next_triangle;
    logic                    degenerate;
  } walk_t;

  typedef struct packed {
    logic                    inside_res;
    logic                    step_found;
    logic [OUT_IDX_BITS-1:0] next_triangle;
    logic                    in_circumcircle;
    logic                    degenerate;
  } result_t;

  typedef struct packed {
    logic advance;
    logic valid;
  } stage_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/tpc_if.sv -----
// tpc_in_if / tpc_out_if: valid-ready channels of the classifier.
// Depends on tpc_pkg for the result index width.
`default_nettype none
interface tpc_in_if #(
  parameter int COORD_BITS = 32,
  parameter int INDEX_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_a_x;
  logic signed [COORD_BITS-1:0] vertex_a_y;
  logic signed [COORD_BITS-1:0] vertex_b_x;
  logic signed [COORD_BITS-1:0] vertex_b_y;
  logic signed [COORD_BITS-1:0] vertex_c_x;
  logic signed [COORD_BITS-1:0] vertex_c_y;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic [INDEX_BITS-1:0]        neighbour_ab;
  logic [INDEX_BITS-1:0]        neighbour_bc;
  logic [INDEX_BITS-1:0]        neighbour_ca;

  modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, query_x, query_y,
                  neighbour_ab, neighbour_bc, neighbour_ca, input ready);
  modport sink (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                vertex_c_x, vertex_c_y, query_x, query_y,
                neighbour_ab, neighbour_bc, neighbour_ca, output ready);
endinterface

interface tpc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             inside_res;
  logic                             step_found;
  logic [tpc_pkg::OUT_IDX_BITS-1:0] next_triangle;
  logic                             in_circumcircle;
  logic                             degenerate;

  modport source (output valid, inside_res, step_found, next_triangle,
                  in_circumcircle, degenerate, input ready);
  modport sink (input valid, inside_res, step_found, next_triangle,
                in_circumcircle, degenerate, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/tpc_front.sv -----
// tpc_front: stages 1-3. Coordinate differences, 2x2 products, edge signs,
// orientation, lifted distances and cofactors. Depends on tpc_pkg.
`default_nettype none
module tpc_front #(
  parameter int COORD_BITS = 32,
  parameter int INDEX_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 advance,
  input  wire logic                                 in_valid,
  input  wire logic signed [COORD_BITS-1:0]         coord [8],
  input  wire logic [INDEX_BITS-1:0]                nbr [3],
  output tpc_pkg::stage_ctrl_t                      ctrl,
  output tpc_pkg::walk_t                            walk,
  output logic                                      orient_neg,
  output logic signed [2*COORD_BITS+2:0]            lift [3],
  output logic signed [2*COORD_BITS+2:0]            cofactor [3]
);
  import tpc_pkg::*;

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;
  localparam int E = P + 1;

  // coordinate slots: ax ay bx by cx cy qx qy
  localparam int DA [22] = '{6,3,2,7, 6,5,4,7, 6,1,0,7, 0,3,1,2, 0,1,2,3,4,5};
  localparam int DB [22] = '{0,1,0,1, 2,3,2,3, 4,5,4,5, 4,5,5,4, 6,7,6,7,6,7};
  // diff slots: 16 adx 17 ady 18 bdx 19 bdy 20 cdx 21 cdy
  localparam int PA [20] = '{0,2,4,6,8,10,12,14, 18,19,20,21,16,17, 16,17,18,19,20,21};
  localparam int PB [20] = '{1,3,5,7,9,11,13,15, 21,20,17,16,19,18, 16,17,18,19,20,21};

  logic signed [D-1:0]   diff [22];
  logic signed [P-1:0]   prod [20];
  logic [INDEX_BITS-1:0] nbr1 [3];
  logic [INDEX_BITS-1:0] nbr2 [3];
  logic                  v1, v2, v3;
  logic signed [E-1:0]   edge_val [3];
  logic signed [E-1:0]   orient;
  logic [2:0]            pos;
  walk_t                 walk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end
  assign ctrl.advance = advance;
  assign ctrl.valid = v3;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 22; i++) begin
        diff[i] <= D'(coord[DA[i]]) - D'(coord[DB[i]]);
      end
      nbr1 <= nbr;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 20; i++) begin
        prod[i] <= diff[PA[i]] * diff[PB[i]];
      end
      nbr2 <= nbr1;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      edge_val[k] = E'(prod[2*k]) - E'(prod[2*k+1]);
      pos[k] = !edge_val[k][E-1] && (edge_val[k] != '0);
    end
    orient = E'(prod[6]) - E'(prod[7]);
    walk_next = '0;
    walk_next.degenerate = (orient == '0);
    // first positive edge in ab, bc, ca order names the next triangle
    if (pos[0]) begin
      walk_next.step_found = 1'b1;
      walk_next.next_triangle = OUT_IDX_BITS'(nbr2[0]);
    end else if (pos[1]) begin
      walk_next.step_found = 1'b1;
      walk_next.next_triangle = OUT_IDX_BITS'(nbr2[1]);
    end else if (pos[2]) begin
      walk_next.step_found = 1'b1;
      walk_next.next_triangle = OUT_IDX_BITS'(nbr2[2]);
    end else begin
      walk_next.inside_res = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      walk <= walk_next;
      orient_neg <= orient[E-1];
      for (int k = 0; k < 3; k++) begin
        cofactor[k] <= E'(prod[8+2*k]) - E'(prod[9+2*k]);
        lift[k] <= E'(prod[14+2*k]) + E'(prod[15+2*k]);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tpc_circle.sv -----
// tpc_circle: stages 4-6. Split wide lift*cofactor products, combine terms,
// sum the incircle determinant and form the result. Depends on tpc_pkg.
`default_nettype none
module tpc_circle #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tpc_pkg::stage_ctrl_t          ctrl_in,
  input  wire tpc_pkg::walk_t                walk_in,
  input  wire logic                          orient_neg_in,
  input  wire logic signed [2*COORD_BITS+2:0] lift [3],
  input  wire logic signed [2*COORD_BITS+2:0] cofactor [3],
  output logic                               out_valid,
  output tpc_pkg::result_t                   result
);
  import tpc_pkg::*;

  localparam int D = COORD_BITS + 1;
  localparam int E = 2 * D + 1;
  localparam int H = E - D;
  localparam int T = 2 * E;
  localparam int W = T + 2;

  logic signed [2*H-1:0]   pp_hh [3];
  logic signed [H+D:0]     pp_hl [3];
  logic signed [H+D:0]     pp_lh [3];
  logic [2*D-1:0]          pp_ll [3];
  logic signed [T-1:0]     term [3];
  logic signed [W-1:0]     det;
  walk_t                   walk4, walk5;
  logic                    on4, on5;
  logic                    v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctrl_in.advance) begin
      v4 <= ctrl_in.valid;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.advance) begin
      for (int k = 0; k < 3; k++) begin
        pp_hh[k] <= $signed(lift[k][E-1:D]) * $signed(cofactor[k][E-1:D]);
        pp_hl[k] <= $signed(lift[k][E-1:D]) * $signed({1'b0, cofactor[k][D-1:0]});
        pp_lh[k] <= $signed({1'b0, lift[k][D-1:0]}) * $signed(cofactor[k][E-1:D]);
        pp_ll[k] <= lift[k][D-1:0] * cofactor[k][D-1:0];
      end
      walk4 <= walk_in;
      on4 <= orient_neg_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.advance) begin
      for (int k = 0; k < 3; k++) begin
        term[k] <= (T'(pp_hh[k]) <<< (2*D)) + (T'(pp_hl[k]) <<< D)
                 + (T'(pp_lh[k]) <<< D) + T'($signed({1'b0, pp_ll[k]}));
      end
      walk5 <= walk4;
      on5 <= on4;
    end
  end

  assign det = W'(term[0]) + W'(term[1]) + W'(term[2]);

  always_ff @(posedge clk) begin
    if (ctrl_in.advance) begin
      result.inside_res <= walk5.inside_res;
      result.step_found <= walk5.step_found;
      result.next_triangle <= walk5.next_triangle;
      result.degenerate <= walk5.degenerate;
      // strict test: determinant sign must match the orientation sign
      result.in_circumcircle <= !walk5.degenerate && (det != '0)
                                && (det[W-1] == on5);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/triangle_point_classifier_core.sv -----
// triangle_point_classifier_core: top level of the point-in-triangle and
// incircle classifier. Depends on tpc_pkg, tpc_if, tpc_front, tpc_circle.
//
// Takes one triangle and query point per clock while the result channel is
// not stalled and returns one result per item, one item per cycle under that
// condition. The six stages are coordinate differences, 2x2 products,
// edge and cofactor sums, split wide products, term combine, determinant
// sum into the output register. All arithmetic is exact on the raw Q16.16
// bits. A stall on the result channel freezes the whole pipeline in place.
`default_nettype none
module triangle_point_classifier_core #(
  parameter int INDEX_BITS = 16,
  parameter int COORD_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  tpc_in_if.sink   query,
  tpc_out_if.source result
);
  import tpc_pkg::*;

  localparam int E = 2 * COORD_BITS + 3;

  logic                         advance;
  logic signed [COORD_BITS-1:0] coord [8];
  logic [INDEX_BITS-1:0]        nbr [3];
  stage_ctrl_t                  ctrl;
  walk_t                        walk;
  logic                         orient_neg;
  logic signed [E-1:0]          lift [3];
  logic signed [E-1:0]          cofactor [3];
  logic                         out_valid;
  result_t                      res;

  // advance whenever the output register is empty or being drained
  assign advance = !out_valid || result.ready;
  assign query.ready = advance;

  assign coord[0] = query.vertex_a_x;
  assign coord[1] = query.vertex_a_y;
  assign coord[2] = query.vertex_b_x;
  assign coord[3] = query.vertex_b_y;
  assign coord[4] = query.vertex_c_x;
  assign coord[5] = query.vertex_c_y;
  assign coord[6] = query.query_x;
  assign coord[7] = query.query_y;
  assign nbr[0] = query.neighbour_ab;
  assign nbr[1] = query.neighbour_bc;
  assign nbr[2] = query.neighbour_ca;

  tpc_front #(.COORD_BITS(COORD_BITS), .INDEX_BITS(INDEX_BITS)) u_front (
    .clk(clk), .rst(rst), .advance(advance), .in_valid(query.valid),
    .coord(coord), .nbr(nbr), .ctrl(ctrl), .walk(walk),
    .orient_neg(orient_neg), .lift(lift), .cofactor(cofactor)
  );

  tpc_circle #(.COORD_BITS(COORD_BITS)) u_circle (
    .clk(clk), .rst(rst), .ctrl_in(ctrl), .walk_in(walk),
    .orient_neg_in(orient_neg), .lift(lift), .cofactor(cofactor),
    .out_valid(out_valid), .result(res)
  );

  assign result.valid = out_valid;
  assign result.inside_res = res.inside_res;
  assign result.step_found = res.step_found;
  assign result.next_triangle = res.next_triangle;
  assign result.in_circumcircle = res.in_circumcircle;
  assign result.degenerate = res.degenerate;

endmodule
`default_nettype wire

// ----- rtl/core/tpc_checker.sv -----
// tpc_checker: port-level assertions on the classifier, bound to the top.
// Depends on tpc_pkg and triangle_point_classifier_core.
`default_nettype none
module tpc_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             inside_res,
  input wire logic                             step_found,
  input wire logic [tpc_pkg::OUT_IDX_BITS-1:0] next_triangle,
  input wire logic                             in_circumcircle,
  input wire logic                             degenerate
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_triangle))
    else $error("result dropped or changed under stall");

  a_walk: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inside_res != step_found)
    else $error("inside and step flags disagree");

  a_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && !step_found |-> next_triangle == '0)
    else $error("next triangle set without a step");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !in_circumcircle)
    else $error("degenerate triangle reports incircle");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind triangle_point_classifier_core tpc_checker u_tpc_checker (
  .clk(clk), .rst(rst), .out_valid(result.valid), .out_ready(result.ready),
  .inside_res(result.inside_res), .step_found(result.step_found),
  .next_triangle(result.next_triangle),
  .in_circumcircle(result.in_circumcircle), .degenerate(result.degenerate)
);
`default_nettype wire

// ----- verif/tb_triangle_point_classifier_core.sv -----
// Self-checking bench for triangle_point_classifier_core: directed and random
// triangles through the valid-ready channels, checked against an exact predictor.
// Depends on tpc_pkg, tpc_if and the classifier RTL.
`timescale 1ns / 100ps
module tb_triangle_point_classifier_core;
  import tpc_pkg::*;

  typedef logic signed [159:0] exact_t;

  typedef struct {
    logic signed [31:0] ax, ay, bx, by, cx, cy, qx, qy;
    logic [15:0]        nab, nbc, nca;
  } tri_query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpc_in_if #(.COORD_BITS(32), .INDEX_BITS(16)) query_if();
  tpc_out_if result_if();

  triangle_point_classifier_core #(.INDEX_BITS(16), .COORD_BITS(32)) uut (
    .clk(clk), .rst(rst), .query(query_if), .result(result_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  result_t pending_results[$];
  int      error_count = 0;
  int      sent_count = 0;
  int      checked_count = 0;
  int      stall_cycles = 0;
  bit      idle_enable = 1'b1;

  // Exact classification on the raw Q16.16 bits.
  function automatic result_t classify(tri_query_t t);
    exact_t ax, ay, bx, by, cx, cy, qx, qy;
    exact_t e_ab, e_bc, e_ca, orient, det;
    exact_t adx, ady, bdx, bdy, cdx, cdy;
    result_t r;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by;
    cx = t.cx; cy = t.cy; qx = t.qx; qy = t.qy;
    e_ab = (qx - ax) * (by - ay) - (bx - ax) * (qy - ay);
    e_bc = (qx - bx) * (cy - by) - (cx - bx) * (qy - by);
    e_ca = (qx - cx) * (ay - cy) - (ax - cx) * (qy - cy);
    r = '0;
    if (e_ab > 0) begin
      r.step_found = 1'b1; r.next_triangle = t.nab;
    end else if (e_bc > 0) begin
      r.step_found = 1'b1; r.next_triangle = t.nbc;
    end else if (e_ca > 0) begin
      r.step_found = 1'b1; r.next_triangle = t.nca;
    end else begin
      r.inside_res = 1'b1;
    end
    orient = (ax - cx) * (by - cy) - (ay - cy) * (bx - cx);
    if (orient == 0) begin
      r.degenerate = 1'b1;
    end else begin
      adx = ax - qx; ady = ay - qy;
      bdx = bx - qx; bdy = by - qy;
      cdx = cx - qx; cdy = cy - qy;
      det = (adx * adx + ady * ady) * (bdx * cdy - bdy * cdx)
          + (bdx * bdx + bdy * bdy) * (cdx * ady - cdy * adx)
          + (cdx * cdx + cdy * cdy) * (adx * bdy - ady * bdx);
      r.in_circumcircle = (det != 0) && ((det < 0) == (orient < 0));
    end
    return r;
  endfunction

  // Hold valid high across back-to-back items; lower it only in a gap.
  task automatic send_item(tri_query_t t);
    query_if.valid        <= 1'b1;
    query_if.vertex_a_x   <= t.ax;
    query_if.vertex_a_y   <= t.ay;
    query_if.vertex_b_x   <= t.bx;
    query_if.vertex_b_y   <= t.by;
    query_if.vertex_c_x   <= t.cx;
    query_if.vertex_c_y   <= t.cy;
    query_if.query_x      <= t.qx;
    query_if.query_y      <= t.qy;
    query_if.neighbour_ab <= t.nab;
    query_if.neighbour_bc <= t.nbc;
    query_if.neighbour_ca <= t.nca;
    do @(posedge clk); while (!query_if.ready);
    pending_results.push_back(classify(t));
    sent_count++;
    if (idle_enable && $urandom_range(99) < 39) begin
      query_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    query_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic tri_query_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                          int qx, int qy);
    tri_query_t t;
    t.ax = ax; t.ay = ay; t.bx = bx; t.by = by;
    t.cx = cx; t.cy = cy; t.qx = qx; t.qy = qy;
    t.nab = 16'($urandom); t.nbc = 16'($urandom); t.nca = 16'($urandom);
    return t;
  endfunction

  function automatic tri_query_t random_item();
    tri_query_t t;
    int center_x, center_y, spread;
    if ($urandom_range(99) < 20) begin
      t = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
    end else begin
      center_x = $urandom;
      center_y = $urandom;
      if ($urandom_range(3) == 0) begin
        center_x = center_x >>> 8; center_y = center_y >>> 8;
      end
      spread = 1 << $urandom_range(1, 24);
      t = make_tri(center_x + $signed($urandom_range(0, 2 * spread)) - spread,
                   center_y + $signed($urandom_range(0, 2 * spread)) - spread,
                   center_x + $signed($urandom_range(0, 2 * spread)) - spread,
                   center_y + $signed($urandom_range(0, 2 * spread)) - spread,
                   center_x + $signed($urandom_range(0, 2 * spread)) - spread,
                   center_y + $signed($urandom_range(0, 2 * spread)) - spread,
                   center_x + $signed($urandom_range(0, 4 * spread)) - 2 * spread,
                   center_y + $signed($urandom_range(0, 4 * spread)) - 2 * spread);
      // Collapse onto a line now and then.
      if ($urandom_range(15) == 0) begin
        t.cx = 2 * t.bx - t.ax; t.cy = 2 * t.by - t.ay;
      end
    end
    return t;
  endfunction

  // Result side: check every transfer, then decide ready for the next edge.
  always @(posedge clk) begin
    result_t got, want;
    if (result_if.valid && result_if.ready) begin
      got.inside_res      = result_if.inside_res;
      got.step_found      = result_if.step_found;
      got.next_triangle   = result_if.next_triangle;
      got.in_circumcircle = result_if.in_circumcircle;
      got.degenerate      = result_if.degenerate;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (got.inside_res !== want.inside_res) begin
          $error("inside_res: expected %0b, got %0b", want.inside_res, got.inside_res);
          error_count++;
        end
        if (got.step_found !== want.step_found) begin
          $error("step_found: expected %0b, got %0b", want.step_found, got.step_found);
          error_count++;
        end
        if (got.next_triangle !== want.next_triangle) begin
          $error("next_triangle: expected %0d, got %0d", want.next_triangle,
                 got.next_triangle);
          error_count++;
        end
        if (got.in_circumcircle !== want.in_circumcircle) begin
          $error("in_circumcircle: expected %0b, got %0b", want.in_circumcircle,
                 got.in_circumcircle);
          error_count++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate, got.degenerate);
          error_count++;
        end
      end
    end
    if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= !idle_enable || ($urandom_range(99) >= 28);
    end
  end

  task automatic test_directed();
    int mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    // Inside a counterclockwise and a clockwise triangle, then outside across each edge.
    send_item(make_tri(0, 0, 65536, 0, 0, 65536, 16384, 16384));
    send_item(make_tri(0, 0, 0, 65536, 65536, 0, 16384, 16384));
    send_item(make_tri(0, 0, 0, 65536, 65536, 0, -100, 100));
    send_item(make_tri(0, 0, 0, 65536, 65536, 0, 60000, 60000));
    send_item(make_tri(0, 0, 0, 65536, 65536, 0, 100, -100));
    send_item(make_tri(0, 0, 65536, 0, 0, 65536, -5, -5));
    // Point on a vertex, on the circumcircle, and at its centre.
    send_item(make_tri(0, 0, 2, 0, 0, 2, 0, 0));
    send_item(make_tri(0, 0, 2, 0, 0, 2, 2, 2));
    send_item(make_tri(0, 0, 2, 0, 0, 2, 1, 1));
    // Collinear and coincident vertices.
    send_item(make_tri(0, 0, 5, 5, 10, 10, 3, 1));
    send_item(make_tri(7, 7, 7, 7, 7, 7, 7, 7));
    send_item(make_tri(mn, mn, mx, mx, 0, 0, mx, mn));
    // Coordinate extremes.
    send_item(make_tri(mn, mn, mx, mn, mn, mx, 0, 0));
    send_item(make_tri(mn, mn, mn, mx, mx, mn, mx, mx));
    send_item(make_tri(mx, mx, mn, mx, mx, mn, mn, mn));
    send_item(make_tri(mx, mn, mn, mn, mn, mx, 1, -1));
    send_item(make_tri(-1, -1, -1, 0, 0, -1, -1, -1));
    drain_results();
  endtask

  task automatic test_random(int count);
    repeat (count) send_item(random_item());
    drain_results();
  endtask

  task automatic test_steady_stream(int count);
    idle_enable = 1'b0;
    repeat (count) send_item(random_item());
    drain_results();
    idle_enable = 1'b1;
  endtask

  // Stall the result side long enough to back the pipeline up into the input.
  task automatic test_backpressure();
    stall_cycles = 60;
    repeat (30) send_item(random_item());
    drain_results();
  endtask

  initial begin
    query_if.valid        = 1'b0;
    query_if.vertex_a_x   = '0;
    query_if.vertex_a_y   = '0;
    query_if.vertex_b_x   = '0;
    query_if.vertex_b_y   = '0;
    query_if.vertex_c_x   = '0;
    query_if.vertex_c_y   = '0;
    query_if.query_x      = '0;
    query_if.query_y      = '0;
    query_if.neighbour_ab = '0;
    query_if.neighbour_bc = '0;
    query_if.neighbour_ca = '0;
    result_if.ready       = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(250);
    test_backpressure();
    test_steady_stream(80);
    test_random(170);

    query_if.valid <= 1'b0;
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end
    $display("Sent %0d triangle queries, checked %0d results (directed, random, stalls).",
             sent_count, checked_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- triangle_point_classifier_core.f -----
rtl/core/tpc_pkg.sv
rtl/core/tpc_if.sv
rtl/core/tpc_front.sv
rtl/core/tpc_circle.sv
rtl/core/triangle_point_classifier_core.sv
rtl/core/tpc_checker.sv
verif/tb_triangle_point_classifier_core.sv
